FILE: src/i2cms_pkg.sv
// Package for the I2C master transfer sequencer.
// Holds the transaction structs, bus status codes, command and error codes.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

    // Default depth of the transmit and receive byte stores.
    localparam int DEFAULT_BUFFER_DEPTH = 32;

    // Request modes.
    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_WRITE  = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_STATUS = 3'd3;
    localparam logic [2:0] MODE_POP    = 3'd4;

    // Bus commands issued to the byte controller.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_SEND  = 3'd3;
    localparam logic [2:0] CMD_ACK   = 3'd4;
    localparam logic [2:0] CMD_NACK  = 3'd5;

    // Error codes.
    localparam logic [2:0] ERR_BUSY      = 3'd0;
    localparam logic [2:0] ERR_DONE      = 3'd1;
    localparam logic [2:0] ERR_SLAW_NACK = 3'd2;
    localparam logic [2:0] ERR_DATA_NACK = 3'd3;
    localparam logic [2:0] ERR_SLAR_NACK = 3'd4;
    localparam logic [2:0] ERR_ARB       = 3'd5;
    localparam logic [2:0] ERR_ILLEGAL   = 3'd6;

    // Bus controller status codes, low three bits masked.
    localparam logic [7:0] STAT_BUS_ERROR = 8'h00;
    localparam logic [7:0] STAT_START     = 8'h08;
    localparam logic [7:0] STAT_REP_START = 8'h10;
    localparam logic [7:0] STAT_SLAW_ACK  = 8'h18;
    localparam logic [7:0] STAT_SLAW_NACK = 8'h20;
    localparam logic [7:0] STAT_DATA_ACK  = 8'h28;
    localparam logic [7:0] STAT_DATA_NACK = 8'h30;
    localparam logic [7:0] STAT_ARB_LOST  = 8'h38;
    localparam logic [7:0] STAT_SLAR_ACK  = 8'h40;
    localparam logic [7:0] STAT_SLAR_NACK = 8'h48;
    localparam logic [7:0] STAT_RX_ACK    = 8'h50;
    localparam logic [7:0] STAT_RX_NACK   = 8'h58;
    localparam logic [7:0] STAT_NO_INFO   = 8'hF8;

    // Controller states.
    typedef enum logic [2:0] {
        CS_READY    = 3'd0,
        CS_INIT     = 3'd1,
        CS_REPSTART = 3'd2,
        CS_MTX      = 3'd3,
        CS_MRX      = 3'd4
    } ctrl_state_t;

    // Request transaction.
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] byte_value;
        logic [4:0] byte_index;
        logic [7:0] transfer_length;
        logic [6:0] device_address;
        logic       repeat_start;
        logic [7:0] status_code;
    } req_t;

    // Result transaction.
    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] send_byte;
        logic       rejected;
        logic       ready_res;
        logic [2:0] error_code;
        logic [7:0] read_byte;
    } rsp_t;

endpackage

`default_nettype wire

FILE: src/i2cms_store.sv
// Byte store of the I2C master transfer sequencer: one write and one read port.
// Registered read data; a write to the read address in the same cycle is forwarded.
// Depends on i2cms_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_store #(
    parameter int DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer.
// Uses i2cms_pkg and two i2cms_store instances for the transmit and receive bytes.
`timescale 1ns / 1ps
`default_nettype none

// The sequencer takes one request transaction per clock cycle while req_stall is low
// and returns exactly one result transaction for each, in order. Control state
// (controller state, error code, hold flag, pointers and counts) is updated in the
// cycle of acceptance; the transmit and receive bytes live in two single-port-read
// memories whose registered read feeds the pending stage, and an output register
// follows it. A stalled result holds one request in flight; a further request is
// stalled until the result side takes the waiting result. No clearing pass follows
// reset.
module i2c_master_transfer_sequencer #(
    parameter int BUFFER_DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire i2cms_pkg::req_t  req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output i2cms_pkg::rsp_t       rsp
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int PW = $clog2(BUFFER_DEPTH + 1);

    // Control state.
    i2cms_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0]    err_reg, err_next;
    logic          hold_reg, hold_next;
    logic [PW-1:0] tx_ptr_reg, tx_ptr_next;
    logic [PW-1:0] tx_cnt_reg, tx_cnt_next;
    logic [PW-1:0] rx_ptr_reg, rx_ptr_next;
    logic [PW-1:0] rx_cnt_reg, rx_cnt_next;

    // Pipeline stage waiting on the memory read, and the output register.
    logic            s1_valid_reg, s1_valid_next;
    i2cms_pkg::rsp_t s1_rsp_reg, s1_rsp_next;
    logic            s1_tx_sel_reg, s1_rx_sel_reg;
    logic            rsp_valid_reg, rsp_valid_next;
    i2cms_pkg::rsp_t rsp_reg, rsp_next;

    // Handshake.
    logic accept;
    logic s1_adv;

    // Store ports.
    logic          tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
    logic [AW-1:0] tx_wr_addr, tx_rd_addr, rx_wr_addr, rx_rd_addr;
    logic [7:0]    tx_wr_data, rx_wr_data, tx_rd_data, rx_rd_data;

    // Per-item decode results.
    logic [2:0]    cmd;
    logic          rej;
    logic [7:0]    status_m;
    logic          is_ready;
    logic          len_ok;
    logic          req_ok;
    logic          tx_avail;
    logic          rx_room;
    logic [PW:0]   rx_ptr_inc;
    logic [PW:0]   rx_ptr_put;
    logic          rx_more_now;
    logic          rx_more_put;
    logic [PW-1:0] rx_ptr_dec;
    logic          idx_ok;
    logic [2:0]    finish_cmd;

    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_adv;
    assign accept    = req_valid && !req_stall;

    assign status_m    = {req.status_code[7:3], 3'b000};
    assign is_ready    = (state_reg == i2cms_pkg::CS_READY) ||
                         (state_reg == i2cms_pkg::CS_REPSTART);
    assign len_ok      = 32'(req.transfer_length) <= BUFFER_DEPTH;
    assign req_ok      = len_ok && is_ready;
    assign idx_ok      = 32'(req.byte_index) < BUFFER_DEPTH;
    assign tx_avail    = tx_ptr_reg < tx_cnt_reg;
    assign rx_room     = 32'(rx_ptr_reg) < BUFFER_DEPTH;
    assign rx_ptr_inc  = {1'b0, rx_ptr_reg} + 1'b1;
    assign rx_ptr_put  = rx_room ? rx_ptr_inc : {1'b0, rx_ptr_reg};
    assign rx_more_now = rx_ptr_inc < {1'b0, rx_cnt_reg};
    assign rx_more_put = (rx_ptr_put + 1'b1) < {1'b0, rx_cnt_reg};
    assign rx_ptr_dec  = rx_ptr_reg - 1'b1;
    assign finish_cmd  = hold_reg ? i2cms_pkg::CMD_START : i2cms_pkg::CMD_STOP;

    // Next control state.
    always_comb
    begin
        state_next  = state_reg;
        err_next    = err_reg;
        hold_next   = hold_reg;
        tx_ptr_next = tx_ptr_reg;
        tx_cnt_next = tx_cnt_reg;
        rx_ptr_next = rx_ptr_reg;
        rx_cnt_next = rx_cnt_reg;
        unique case (req.mode)
            i2cms_pkg::MODE_WRITE,
            i2cms_pkg::MODE_READ:
            begin
                if (req_ok)
                begin
                    hold_next  = req.repeat_start;
                    state_next = i2cms_pkg::CS_INIT;
                    // From a held repeated start the first byte goes out at once.
                    tx_ptr_next = (state_reg == i2cms_pkg::CS_REPSTART) ?
                                  PW'(1) : '0;
                    if (req.mode == i2cms_pkg::MODE_READ)
                    begin
                        tx_cnt_next = PW'(1);
                        rx_ptr_next = '0;
                        rx_cnt_next = PW'(req.transfer_length);
                    end
                    else
                    begin
                        tx_cnt_next = PW'(req.transfer_length);
                    end
                end
            end
            i2cms_pkg::MODE_STATUS:
            begin
                unique case (status_m)
                    i2cms_pkg::STAT_START,
                    i2cms_pkg::STAT_SLAW_ACK,
                    i2cms_pkg::STAT_DATA_ACK:
                    begin
                        if (status_m == i2cms_pkg::STAT_SLAW_ACK)
                        begin
                            state_next = i2cms_pkg::CS_MTX;
                        end
                        if (tx_avail)
                        begin
                            tx_ptr_next = tx_ptr_reg + 1'b1;
                            err_next    = i2cms_pkg::ERR_BUSY;
                        end
                        else
                        begin
                            err_next = i2cms_pkg::ERR_DONE;
                            if (!hold_reg)
                            begin
                                state_next = i2cms_pkg::CS_READY;
                            end
                        end
                    end
                    i2cms_pkg::STAT_SLAR_ACK:
                    begin
                        state_next = i2cms_pkg::CS_MRX;
                        err_next   = i2cms_pkg::ERR_BUSY;
                    end
                    i2cms_pkg::STAT_RX_ACK:
                    begin
                        rx_ptr_next = rx_ptr_put[PW-1:0];
                        err_next    = i2cms_pkg::ERR_BUSY;
                    end
                    i2cms_pkg::STAT_RX_NACK,
                    i2cms_pkg::STAT_SLAW_NACK,
                    i2cms_pkg::STAT_DATA_NACK,
                    i2cms_pkg::STAT_SLAR_NACK,
                    i2cms_pkg::STAT_ARB_LOST:
                    begin
                        unique case (status_m)
                            i2cms_pkg::STAT_RX_NACK:
                            begin
                                rx_ptr_next = rx_ptr_put[PW-1:0];
                                err_next    = i2cms_pkg::ERR_DONE;
                            end
                            i2cms_pkg::STAT_SLAW_NACK: err_next = i2cms_pkg::ERR_SLAW_NACK;
                            i2cms_pkg::STAT_DATA_NACK: err_next = i2cms_pkg::ERR_DATA_NACK;
                            i2cms_pkg::STAT_SLAR_NACK: err_next = i2cms_pkg::ERR_SLAR_NACK;
                            default:                   err_next = i2cms_pkg::ERR_ARB;
                        endcase
                        if (!hold_reg)
                        begin
                            state_next = i2cms_pkg::CS_READY;
                        end
                    end
                    i2cms_pkg::STAT_REP_START:
                    begin
                        state_next = i2cms_pkg::CS_REPSTART;
                    end
                    i2cms_pkg::STAT_BUS_ERROR:
                    begin
                        err_next   = i2cms_pkg::ERR_ILLEGAL;
                        state_next = i2cms_pkg::CS_READY;
                    end
                    default:
                    begin
                        // No-information code and unknown codes leave the state alone.
                    end
                endcase
            end
            i2cms_pkg::MODE_POP:
            begin
                if (rx_ptr_reg != '0)
                begin
                    rx_ptr_next = rx_ptr_dec;
                end
            end
            default:
            begin
                // Loads and unknown modes leave the control state alone.
            end
        endcase
    end

    // Bus command, rejection and store accesses.
    always_comb
    begin
        cmd        = i2cms_pkg::CMD_NONE;
        rej        = 1'b0;
        tx_wr_en   = 1'b0;
        tx_wr_addr = AW'(req.byte_index);
        tx_wr_data = req.byte_value;
        tx_rd_en   = 1'b0;
        tx_rd_addr = tx_ptr_reg[AW-1:0];
        rx_wr_en   = 1'b0;
        rx_wr_addr = rx_ptr_reg[AW-1:0];
        rx_wr_data = req.byte_value;
        rx_rd_en   = 1'b0;
        rx_rd_addr = rx_ptr_dec[AW-1:0];
        unique case (req.mode)
            i2cms_pkg::MODE_LOAD:
            begin
                if (!is_ready)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    tx_wr_en = idx_ok;
                end
            end
            i2cms_pkg::MODE_WRITE,
            i2cms_pkg::MODE_READ:
            begin
                if (!req_ok)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    // A read places the address byte with the read bit at entry 0.
                    if (req.mode == i2cms_pkg::MODE_READ)
                    begin
                        tx_wr_en   = 1'b1;
                        tx_wr_addr = '0;
                        tx_wr_data = {req.device_address, 1'b1};
                    end
                    if (state_reg == i2cms_pkg::CS_REPSTART)
                    begin
                        cmd        = i2cms_pkg::CMD_SEND;
                        tx_rd_en   = 1'b1;
                        tx_rd_addr = '0;
                    end
                    else
                    begin
                        cmd = i2cms_pkg::CMD_START;
                    end
                end
            end
            i2cms_pkg::MODE_STATUS:
            begin
                unique case (status_m)
                    i2cms_pkg::STAT_START,
                    i2cms_pkg::STAT_SLAW_ACK,
                    i2cms_pkg::STAT_DATA_ACK:
                    begin
                        if (tx_avail)
                        begin
                            cmd      = i2cms_pkg::CMD_SEND;
                            tx_rd_en = 1'b1;
                        end
                        else
                        begin
                            cmd = finish_cmd;
                        end
                    end
                    i2cms_pkg::STAT_SLAR_ACK:
                    begin
                        cmd = rx_more_now ? i2cms_pkg::CMD_ACK : i2cms_pkg::CMD_NACK;
                    end
                    i2cms_pkg::STAT_RX_ACK:
                    begin
                        rx_wr_en = rx_room;
                        cmd = rx_more_put ? i2cms_pkg::CMD_ACK : i2cms_pkg::CMD_NACK;
                    end
                    i2cms_pkg::STAT_RX_NACK:
                    begin
                        rx_wr_en = rx_room;
                        cmd      = finish_cmd;
                    end
                    i2cms_pkg::STAT_SLAW_NACK,
                    i2cms_pkg::STAT_DATA_NACK,
                    i2cms_pkg::STAT_SLAR_NACK,
                    i2cms_pkg::STAT_ARB_LOST:
                    begin
                        cmd = finish_cmd;
                    end
                    i2cms_pkg::STAT_BUS_ERROR:
                    begin
                        cmd = i2cms_pkg::CMD_STOP;
                    end
                    i2cms_pkg::STAT_REP_START,
                    i2cms_pkg::STAT_NO_INFO:
                    begin
                        cmd = i2cms_pkg::CMD_NONE;
                    end
                    default:
                    begin
                        cmd = i2cms_pkg::CMD_NONE;
                    end
                endcase
            end
            i2cms_pkg::MODE_POP:
            begin
                rx_rd_en = (rx_ptr_reg != '0);
            end
            default:
            begin
                cmd = i2cms_pkg::CMD_NONE;
            end
        endcase
    end

    // Result fields known at acceptance; the store bytes join from the registered store reads at the output register.
    always_comb
    begin
        s1_rsp_next             = '0;
        s1_rsp_next.bus_command = cmd;
        s1_rsp_next.rejected    = rej;
        s1_rsp_next.ready_res   = (state_next == i2cms_pkg::CS_READY) ||
                                  (state_next == i2cms_pkg::CS_REPSTART);
        s1_rsp_next.error_code  = err_next;
    end

    always_comb
    begin
        rsp_next           = s1_rsp_reg;
        rsp_next.send_byte = s1_tx_sel_reg ? tx_rd_data : 8'h00;
        rsp_next.read_byte = s1_rx_sel_reg ? rx_rd_data : 8'h00;
    end

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign rsp_valid_next = s1_adv || (rsp_valid_reg && rsp_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2cms_pkg::CS_READY;
            err_reg       <= i2cms_pkg::ERR_DONE;
            hold_reg      <= 1'b0;
            tx_ptr_reg    <= '0;
            tx_cnt_reg    <= '0;
            rx_ptr_reg    <= '0;
            rx_cnt_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                state_reg  <= state_next;
                err_reg    <= err_next;
                hold_reg   <= hold_next;
                tx_ptr_reg <= tx_ptr_next;
                tx_cnt_reg <= tx_cnt_next;
                rx_ptr_reg <= rx_ptr_next;
                rx_cnt_reg <= rx_cnt_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rsp_reg    <= s1_rsp_next;
            s1_tx_sel_reg <= tx_rd_en;
            s1_rx_sel_reg <= rx_rd_en;
        end
        if (s1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Transmit and receive byte stores.
    i2cms_store #(
        .DEPTH(BUFFER_DEPTH)
    ) u_tx_store (
        .clk     (clk),
        .wr_en   (accept && tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (accept && tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    i2cms_store #(
        .DEPTH(BUFFER_DEPTH)
    ) u_rx_store (
        .clk     (clk),
        .wr_en   (accept && rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (accept && rx_rd_en),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // Requests are held back only while both result slots are full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("request stalled without a full pipeline");

    // A pending transaction moves to the output once the output is free.
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !(rsp_valid_reg && rsp_stall)) |=> rsp_valid_reg)
        else $error("pending transaction did not reach the output");

    // Pointers and counts never pass the store depth.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(tx_ptr_reg) <= BUFFER_DEPTH) && (32'(tx_cnt_reg) <= BUFFER_DEPTH) &&
        (32'(rx_ptr_reg) <= BUFFER_DEPTH) && (32'(rx_cnt_reg) <= BUFFER_DEPTH))
        else $error("pointer or count beyond store depth");

    // A rejected request never drives the bus.
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.rejected) |-> (rsp.bus_command == i2cms_pkg::CMD_NONE))
        else $error("rejected request issued a bus command");

    // A transmit byte is shown only with a send command.
    a_send_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.send_byte != 8'h00)) |->
        (rsp.bus_command == i2cms_pkg::CMD_SEND))
        else $error("send byte without send command");
`endif

endmodule

`default_nettype wire
